// ===== hdl/sed_pkg.sv =====
package sed_pkg;

    // Defaults for the top-level parameters
    localparam int FRAME_SAMPLES_DEF = 320;
    localparam int AGE_BITS_DEF      = 16;

    // Field widths fixed by the interface
    localparam int CMD_W      = 3;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 31;
    localparam int ENERGY_W   = 39;
    localparam int PEAK_W     = 16;
    localparam int THR_W      = 15;
    localparam int THRSQ_W    = 30;
    localparam int RUN_W      = 10;
    localparam int WIN_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINALIZE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE_ENABLE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEECH        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_HOLD      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_WINDOW       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEECH        = 3'd5;

    // Register reset values
    localparam logic [THR_W-1:0] RST_SILENCE_THRESHOLD = 15'd655;
    localparam logic             RST_WAKE_ENABLE       = 1'b0;
    localparam logic [RUN_W-1:0] RST_MIN_SPEECH        = 10'd15;
    localparam logic [RUN_W-1:0] RST_SILENCE_HOLD      = 10'd40;
    localparam logic [WIN_W-1:0] RST_IDLE_WINDOW       = 16'd125;
    localparam logic [WIN_W-1:0] RST_MAX_SPEECH        = 16'd450;

    // Peak floor of the quiet test: 0.06 of full scale
    localparam logic [PEAK_W-1:0] PEAK_FLOOR = 16'd1967;
    localparam logic [RUN_W-1:0]  RUN_MAX    = '1;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
        logic                       speech_flag;
    } in_item_t;

    typedef struct packed {
        logic                frame_done;
        logic [ENERGY_W-1:0] frame_energy;
        logic [PEAK_W-1:0]   frame_peak;
        logic                speech_active;
        logic                activity_changed;
        logic                wake_hit;
        logic                capture_done;
        logic                had_speech;
    } out_item_t;

    // Front stage register contents
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MAG_W-1:0] mag;
        logic             frame_last;
        logic             speech_flag;
    } f_item_t;

    // Queue entry handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MAG_W-1:0] mag;
        logic [SQ_W-1:0]  sq;
        logic             frame_last;
        logic             speech_flag;
    } q_item_t;

    // Configuration, with the derived limits
    typedef struct packed {
        logic [THR_W-1:0]   thr;
        logic               wake_enable;
        logic [RUN_W-1:0]   min_speech;
        logic [RUN_W-1:0]   silence_hold;
        logic [WIN_W-1:0]   idle_window;
        logic [WIN_W-1:0]   max_speech;
        logic [THRSQ_W-1:0] thr_sq;
        logic [PEAK_W-1:0]  peak_lim;
    } cfg_t;

endpackage

// ===== hdl/sed_front.sv =====
module sed_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  sed_pkg::in_item_t s_item,
    input  logic              s_valid,
    output logic              s_ready,
    output sed_pkg::q_item_t  q_item,
    output logic              q_valid,
    input  logic              q_ready
);
    import sed_pkg::*;

    logic                 f_valid_reg;
    f_item_t              f_item_reg;
    logic                 f_free;
    logic                 known;
    logic [SAMPLE_W-1:0]  raw;
    logic [MAG_W-1:0]     mag;
    logic [SQ_W-1:0]      prod;

    // Unknown commands are taken and dropped here.
    always_comb begin
        unique case (s_item.command) inside
            CMD_SAMPLE, CMD_START, CMD_ABORT, CMD_FINALIZE, CMD_TICK: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign raw    = s_item.sample;
    assign mag    = raw[SAMPLE_W-1] ? MAG_W'(~raw + 16'd1) : raw;
    assign f_free = !f_valid_reg || q_ready;
    assign s_ready = f_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_free) begin
            f_valid_reg <= s_valid && known;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_free && s_valid) begin
            f_item_reg.cmd         <= s_item.command;
            f_item_reg.mag         <= mag;
            f_item_reg.frame_last  <= s_item.frame_last;
            f_item_reg.speech_flag <= s_item.speech_flag;
        end
    end

    // Square of the magnitude; registered at the queue.
    assign prod = SQ_W'(f_item_reg.mag) * SQ_W'(f_item_reg.mag);

    assign q_valid            = f_valid_reg;
    assign q_item.cmd         = f_item_reg.cmd;
    assign q_item.mag         = f_item_reg.mag;
    assign q_item.sq          = prod;
    assign q_item.frame_last  = f_item_reg.frame_last;
    assign q_item.speech_flag = f_item_reg.speech_flag;

endmodule

// ===== hdl/sed_queue.sv =====
module sed_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  sed_pkg::q_item_t wr_item,
    input  logic             wr_valid,
    output logic             wr_ready,
    output sed_pkg::q_item_t rd_item,
    output logic             rd_valid,
    input  logic             rd_ready
);
    import sed_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_item_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

// ===== hdl/sed_back.sv =====
module sed_back #(
    parameter int FRAME_SAMPLES = sed_pkg::FRAME_SAMPLES_DEF,
    parameter int AGE_BITS      = sed_pkg::AGE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sed_pkg::cfg_t      cfg,
    input  sed_pkg::q_item_t   q_item,
    input  logic               q_valid,
    output logic               q_ready,
    output sed_pkg::out_item_t m_item,
    output logic               m_valid,
    input  logic               m_ready
);
    import sed_pkg::*;

    localparam int CNT_W = $clog2(FRAME_SAMPLES + 1);
    localparam int LIM_W = THRSQ_W + CNT_W;
    localparam int QW    = (LIM_W > ENERGY_W) ? LIM_W : ENERGY_W;
    localparam int CMP_W = (AGE_BITS > WIN_W) ? AGE_BITS : WIN_W;

    // Capture state
    logic                capturing_reg, capturing_next;
    logic                prev_speech_reg, prev_speech_next;
    logic                confirmed_reg, confirmed_next;
    logic [RUN_W-1:0]    speech_run_reg, speech_run_next;
    logic [RUN_W-1:0]    silence_run_reg, silence_run_next;
    logic [AGE_BITS-1:0] capture_age_reg, capture_age_next;
    logic [AGE_BITS-1:0] speech_age_reg, speech_age_next;
    // Frame accumulators
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [LIM_W-1:0]    lim_reg, lim_next;
    logic [PEAK_W-1:0]   peak_reg, peak_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                m_valid_reg;
    out_item_t           m_item_reg;

    logic                pop;
    logic                clr;
    logic                start;
    out_item_t           res;
    logic                res_valid;

    logic [ENERGY_W:0]   energy_sum;
    logic [ENERGY_W-1:0] e_acc;
    logic [LIM_W-1:0]    lim_acc;
    logic [PEAK_W-1:0]   peak_acc;
    logic [CNT_W-1:0]    cnt_acc;
    logic                frame_end;
    logic [RUN_W-1:0]    run_inc, sil_inc;
    logic [AGE_BITS-1:0] age_inc, sage_inc;
    logic                flag;
    logic [RUN_W-1:0]    speech_run_f, silence_run_f;
    logic [AGE_BITS-1:0] sage_f;
    logic                confirm_now, conf_f;
    logic                idle_hit, max_hit, quiet, end_f;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    // Per-sample accumulation
    assign energy_sum = {1'b0, energy_reg} + (ENERGY_W+1)'(q_item.sq);
    assign e_acc      = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
    assign lim_acc    = lim_reg + LIM_W'(cfg.thr_sq);
    assign peak_acc   = (q_item.mag > peak_reg) ? q_item.mag : peak_reg;
    assign cnt_acc    = cnt_reg + 1'b1;
    assign frame_end  = q_item.frame_last || (cnt_acc == CNT_W'(FRAME_SAMPLES));

    // Saturating counters
    assign run_inc  = (speech_run_reg == RUN_MAX) ? speech_run_reg : speech_run_reg + 1'b1;
    assign sil_inc  = (silence_run_reg == RUN_MAX) ? silence_run_reg : silence_run_reg + 1'b1;
    assign age_inc  = (capture_age_reg == '1) ? capture_age_reg : capture_age_reg + 1'b1;
    assign sage_inc = (speech_age_reg == '1) ? speech_age_reg : speech_age_reg + 1'b1;

    // Frame-end decisions
    assign flag          = q_item.speech_flag;
    assign speech_run_f  = flag ? run_inc : '0;
    assign silence_run_f = flag ? '0 : sil_inc;
    assign confirm_now   = !confirmed_reg && flag && (speech_run_f >= cfg.min_speech);
    assign conf_f        = confirmed_reg || confirm_now;
    assign sage_f        = confirm_now ? '0 : (confirmed_reg ? sage_inc : speech_age_reg);
    assign idle_hit      = CMP_W'(age_inc) >= CMP_W'(cfg.idle_window);
    assign max_hit       = CMP_W'(sage_f) >= CMP_W'(cfg.max_speech);
    assign quiet         = (QW'(e_acc) < QW'(lim_acc)) && (peak_acc < cfg.peak_lim);
    assign end_f         = conf_f ? (max_hit || ((silence_run_f >= cfg.silence_hold) && quiet))
                                  : idle_hit;

    always_comb begin
        capturing_next   = capturing_reg;
        prev_speech_next = prev_speech_reg;
        confirmed_next   = confirmed_reg;
        speech_run_next  = speech_run_reg;
        silence_run_next = silence_run_reg;
        capture_age_next = capture_age_reg;
        speech_age_next  = speech_age_reg;
        energy_next      = energy_reg;
        lim_next         = lim_reg;
        peak_next        = peak_reg;
        cnt_next         = cnt_reg;
        res              = '0;
        res_valid        = 1'b0;
        clr              = 1'b0;
        start            = 1'b0;

        if (pop) begin
            unique case (q_item.cmd)
                CMD_START: begin
                    clr   = 1'b1;
                    start = 1'b1;
                end
                CMD_ABORT: begin
                    clr = 1'b1;
                end
                CMD_FINALIZE: begin
                    res_valid        = 1'b1;
                    res.capture_done = 1'b1;
                    res.had_speech   = confirmed_reg;
                    clr              = 1'b1;
                end
                CMD_TICK: begin
                    if (capturing_reg) begin
                        capture_age_next = age_inc;
                        if (confirmed_reg) begin
                            speech_age_next = sage_inc;
                        end
                        if (!confirmed_reg && idle_hit) begin
                            res_valid        = 1'b1;
                            res.capture_done = 1'b1;
                            clr              = 1'b1;
                        end
                    end
                end
                CMD_SAMPLE: begin
                    if (capturing_reg) begin
                        if (!frame_end) begin
                            energy_next = e_acc;
                            lim_next    = lim_acc;
                            peak_next   = peak_acc;
                            cnt_next    = cnt_acc;
                        end else begin
                            energy_next = '0;
                            lim_next    = '0;
                            peak_next   = '0;
                            cnt_next    = '0;

                            res_valid            = 1'b1;
                            res.frame_done       = 1'b1;
                            res.frame_energy     = e_acc;
                            res.frame_peak       = peak_acc;
                            res.speech_active    = flag;
                            res.activity_changed = flag != prev_speech_reg;
                            res.wake_hit         = cfg.wake_enable && flag;

                            prev_speech_next = flag;
                            speech_run_next  = speech_run_f;
                            silence_run_next = silence_run_f;
                            capture_age_next = age_inc;
                            speech_age_next  = sage_f;
                            confirmed_next   = conf_f;

                            if (end_f) begin
                                res.capture_done = 1'b1;
                                res.had_speech   = conf_f;
                                clr              = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (clr) begin
                capturing_next   = start;
                prev_speech_next = 1'b0;
                confirmed_next   = 1'b0;
                speech_run_next  = '0;
                silence_run_next = '0;
                capture_age_next = '0;
                speech_age_next  = '0;
                energy_next      = '0;
                lim_next         = '0;
                peak_next        = '0;
                cnt_next         = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg   <= 1'b0;
            prev_speech_reg <= 1'b0;
            confirmed_reg   <= 1'b0;
            speech_run_reg  <= '0;
            silence_run_reg <= '0;
            capture_age_reg <= '0;
            speech_age_reg  <= '0;
            energy_reg      <= '0;
            lim_reg         <= '0;
            peak_reg        <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            capturing_reg   <= capturing_next;
            prev_speech_reg <= prev_speech_next;
            confirmed_reg   <= confirmed_next;
            speech_run_reg  <= speech_run_next;
            silence_run_reg <= silence_run_next;
            capture_age_reg <= capture_age_next;
            speech_age_reg  <= speech_age_next;
            energy_reg      <= energy_next;
            lim_reg         <= lim_next;
            peak_reg        <= peak_next;
            cnt_reg         <= cnt_next;
            if (q_ready) begin
                m_valid_reg <= pop && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && res_valid) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(FRAME_SAMPLES))
        else $error("frame sample count reached the frame length without closing");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !capturing_reg |-> (energy_reg == '0) && (cnt_reg == '0) && !confirmed_reg)
        else $error("accumulators or confirmation left over outside a capture");

    a_age_confirmed: assert property (@(posedge aclk) disable iff (!aresetn)
        (speech_age_reg != '0) |-> confirmed_reg)
        else $error("speech age running without confirmed speech");

    a_nonframe_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_item_reg.frame_done) |-> m_item_reg.capture_done)
        else $error("result neither reports a frame nor ends a capture");

endmodule

// ===== hdl/speech_endpoint_detector_unit.sv =====
// Channel  | Direction | Handshake          | Content
// ---------+-----------+--------------------+-----------------------------------------
// s_       | in        | s_valid / s_ready  | s_item: command, sample, frame mark, flag
// m_       | out       | m_valid / m_ready  | m_item: frame report and capture end
// cfg_     | in        | cfg_we, no wait    | cfg_index selects, cfg_wdata carries value
//
// The block takes one item in every cycle unless s_ready is held low. Each item
// passes the front stage register, the two-entry queue and the output
// register of the back end, which updates all capture state at once.
// Reset is synchronous and active low; the configuration returns to its defaults.
// A stalled result output fills the queue and then holds s_ready low.
module speech_endpoint_detector_unit #(
    parameter int FRAME_SAMPLES = sed_pkg::FRAME_SAMPLES_DEF,
    parameter int AGE_BITS      = sed_pkg::AGE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sed_pkg::in_item_t                  s_item,
    input  logic                               s_valid,
    output logic                               s_ready,
    output sed_pkg::out_item_t                 m_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               cfg_we,
    input  logic [sed_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sed_pkg::*;

    // Configuration registers, to be written by the user only while the block is idle; the block does not enforce it.
    logic [THR_W-1:0]   thr_reg;
    logic               wake_reg;
    logic [RUN_W-1:0]   min_speech_reg;
    logic [RUN_W-1:0]   hold_reg;
    logic [WIN_W-1:0]   idle_reg;
    logic [WIN_W-1:0]   max_reg;

    // Limits derived from the threshold. They settle in the cycle after a write,
    // well before any item can reach the back end.
    logic [THRSQ_W-1:0] thr_sq_reg;
    logic [PEAK_W-1:0]  peak_lim_reg;
    logic [PEAK_W-1:0]  thr_x2;

    cfg_t               cfg;
    q_item_t            fq_item;
    logic               fq_valid;
    logic               fq_ready;
    q_item_t            qb_item;
    logic               qb_valid;
    logic               qb_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= RST_SILENCE_THRESHOLD;
            wake_reg       <= RST_WAKE_ENABLE;
            min_speech_reg <= RST_MIN_SPEECH;
            hold_reg       <= RST_SILENCE_HOLD;
            idle_reg       <= RST_IDLE_WINDOW;
            max_reg        <= RST_MAX_SPEECH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SILENCE_THRESHOLD: thr_reg        <= cfg_wdata[THR_W-1:0];
                REG_WAKE_ENABLE:       wake_reg       <= cfg_wdata[0];
                REG_MIN_SPEECH:        min_speech_reg <= cfg_wdata[RUN_W-1:0];
                REG_SILENCE_HOLD:      hold_reg       <= cfg_wdata[RUN_W-1:0];
                REG_IDLE_WINDOW:       idle_reg       <= cfg_wdata[WIN_W-1:0];
                REG_MAX_SPEECH:        max_reg        <= cfg_wdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The quiet test compares the frame energy with T squared per sample and
    // the peak with the larger of twice T and the fixed floor.
    assign thr_x2 = {thr_reg, 1'b0};

    always_ff @(posedge aclk) begin
        thr_sq_reg   <= THRSQ_W'(thr_reg) * THRSQ_W'(thr_reg);
        peak_lim_reg <= (thr_x2 < PEAK_FLOOR) ? PEAK_FLOOR : thr_x2;
    end

    assign cfg.thr          = thr_reg;
    assign cfg.wake_enable  = wake_reg;
    assign cfg.min_speech   = min_speech_reg;
    assign cfg.silence_hold = hold_reg;
    assign cfg.idle_window  = idle_reg;
    assign cfg.max_speech   = max_reg;
    assign cfg.thr_sq       = thr_sq_reg;
    assign cfg.peak_lim     = peak_lim_reg;

    // Front: takes items, drops unknown commands, forms magnitude and square.
    sed_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_item  (fq_item),
        .q_valid (fq_valid),
        .q_ready (fq_ready)
    );

    // Short queue so that the front keeps accepting while a result waits.
    sed_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_item  (fq_item),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .rd_item  (qb_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready)
    );

    // Back: frame accumulation, speech runs, endpoint decisions, result register.
    sed_back #(
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .AGE_BITS      (AGE_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_item  (qb_item),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    import sed_pkg::*;

    // The block runs with its default frame length and age width, so the
    // predictor below uses the same figures.
    localparam int FRAME_LEN = FRAME_SAMPLES_DEF;

    // Command codes that the block must ignore without a result.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // Cycles allowed after the last expected item before the block counts as
    // idle. An item passes the front register, the queue and the output register, so this leaves slack.
    localparam int SETTLE_CYCLES = 8;

    localparam logic [63:0] ENERGY_CAP = (64'd1 << ENERGY_W) - 64'd1;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    in_item_t               s_item = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    out_item_t              m_item;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    speech_endpoint_detector_unit #(
        .FRAME_SAMPLES(FRAME_LEN),
        .AGE_BITS(AGE_BITS_DEF)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_item(s_item),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_item(m_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // A hard ceiling on the run, far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("speech_endpoint_detector_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor of the endpoint decision. It keeps its own copy of the
    // configuration and of the capture state and is updated once for every
    // item that the block accepts, in the order of acceptance.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]        set_thr;
    logic                    set_wake;
    logic [RUN_W-1:0]        set_min_speech;
    logic [RUN_W-1:0]        set_hold;
    logic [WIN_W-1:0]        set_idle_window;
    logic [WIN_W-1:0]        set_max_speech;

    bit                      cap_on;
    bit                      prev_flag;
    bit                      confirmed;
    logic [RUN_W-1:0]        speech_run;
    logic [RUN_W-1:0]        silence_run;
    logic [AGE_BITS_DEF-1:0] cap_age;
    logic [AGE_BITS_DEF-1:0] speech_age;
    logic [ENERGY_W-1:0]     acc_energy;
    logic [PEAK_W-1:0]       acc_peak;
    int                      acc_count;

    out_item_t expected_results[$];
    int        fail_count = 0;

    // Idling controls, changed by the tests from one phase to the next.
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int rx_hold_left  = 0;

    function automatic void clear_capture_state();
        cap_on      = 1'b0;
        prev_flag   = 1'b0;
        confirmed   = 1'b0;
        speech_run  = '0;
        silence_run = '0;
        cap_age     = '0;
        speech_age  = '0;
        acc_energy  = '0;
        acc_peak    = '0;
        acc_count   = 0;
    endfunction

    function automatic void reset_model();
        set_thr         = RST_SILENCE_THRESHOLD;
        set_wake        = RST_WAKE_ENABLE;
        set_min_speech  = RST_MIN_SPEECH;
        set_hold        = RST_SILENCE_HOLD;
        set_idle_window = RST_IDLE_WINDOW;
        set_max_speech  = RST_MAX_SPEECH;
        clear_capture_state();
    endfunction

    function automatic void end_capture(inout out_item_t res, input bit had);
        res.capture_done = 1'b1;
        res.had_speech   = had;
        clear_capture_state();
    endfunction

    // Returns 1 when the item yields a result, which is then left in res.
    function automatic bit endpoint_predict(input in_item_t it, output out_item_t res);
        logic [15:0] raw;
        logic [15:0] mag;
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] thr64;
        logic [63:0] plim;
        logic [PEAK_W-1:0] p;
        bit flag;
        bit quiet;
        res = '0;
        case (it.command)
            CMD_START: begin
                clear_capture_state();
                cap_on = 1'b1;
                return 1'b0;
            end
            CMD_ABORT: begin
                clear_capture_state();
                return 1'b0;
            end
            CMD_FINALIZE: begin
                end_capture(res, confirmed);
                return 1'b1;
            end
            CMD_TICK: begin
                if (!cap_on)
                    return 1'b0;
                if (cap_age != '1)
                    cap_age++;
                if (confirmed && speech_age != '1)
                    speech_age++;
                if (!confirmed && cap_age >= set_idle_window) begin
                    end_capture(res, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            CMD_SAMPLE: begin
                if (!cap_on)
                    return 1'b0;
                raw = it.sample;
                mag = raw[15] ? (~raw + 16'd1) : raw;
                e = 64'(acc_energy) + 64'(mag) * 64'(mag);
                if (e > ENERGY_CAP)
                    e = ENERGY_CAP;
                acc_energy = e[ENERGY_W-1:0];
                if (mag > acc_peak)
                    acc_peak = mag;
                acc_count++;
                if (!it.frame_last && acc_count < FRAME_LEN)
                    return 1'b0;

                // The frame is complete: report it and move the runs on.
                e = 64'(acc_energy);
                p = acc_peak;
                n = 64'(acc_count);
                acc_energy = '0;
                acc_peak   = '0;
                acc_count  = 0;
                flag = it.speech_flag;

                res.frame_done       = 1'b1;
                res.frame_energy     = e[ENERGY_W-1:0];
                res.frame_peak       = p;
                res.speech_active    = flag;
                res.activity_changed = (flag != prev_flag);
                res.wake_hit         = set_wake && flag;
                prev_flag = flag;

                if (flag) begin
                    if (speech_run != RUN_MAX)
                        speech_run++;
                    silence_run = '0;
                end else begin
                    if (silence_run != RUN_MAX)
                        silence_run++;
                    speech_run = '0;
                end
                if (cap_age != '1)
                    cap_age++;
                if (confirmed && speech_age != '1)
                    speech_age++;
                if (!confirmed && flag && speech_run >= set_min_speech) begin
                    confirmed  = 1'b1;
                    speech_age = '0;
                end

                if (!confirmed) begin
                    if (cap_age >= set_idle_window)
                        end_capture(res, 1'b0);
                    return 1'b1;
                end
                if (speech_age >= set_max_speech) begin
                    end_capture(res, 1'b1);
                    return 1'b1;
                end
                thr64 = 64'(set_thr);
                plim  = 64'd2 * thr64;
                if (plim < 64'(PEAK_FLOOR))
                    plim = 64'(PEAK_FLOOR);
                quiet = (e < thr64 * thr64 * n) && (64'(p) < plim);
                if (silence_run >= set_hold && quiet)
                    end_capture(res, 1'b1);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side. The receiver drops m_ready at random, or for a whole
    // hold-off stretch when a test asks for one. The checker compares every
    // accepted result with the oldest outstanding expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing outstanding: %p", m_item);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("frame_done", 64'(want.frame_done), 64'(m_item.frame_done));
                check_field("frame_energy", 64'(want.frame_energy),
                            64'(m_item.frame_energy));
                check_field("frame_peak", 64'(want.frame_peak), 64'(m_item.frame_peak));
                check_field("speech_active", 64'(want.speech_active),
                            64'(m_item.speech_active));
                check_field("activity_changed", 64'(want.activity_changed),
                            64'(m_item.activity_changed));
                check_field("wake_hit", 64'(want.wake_hit), 64'(m_item.wake_hit));
                check_field("capture_done", 64'(want.capture_done),
                            64'(m_item.capture_done));
                check_field("had_speech", 64'(want.had_speech), 64'(m_item.had_speech));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge at which it is taken. Any idle
    // gap comes before valid is raised; once raised it stays high, so back
    // to back items keep valid up without a drop in between.
    task automatic send_item(input in_item_t it);
        out_item_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (endpoint_predict(it, res))
            expected_results.push_back(res);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input int smp,
                               input bit last, input bit flag);
        in_item_t it;
        it.command     = cmd;
        it.sample      = 16'(smp);
        it.frame_last  = last;
        it.speech_flag = flag;
        send_item(it);
    endtask

    // Stops offering items and waits until every expected result has come
    // back. A trailing start or abort gives no result, so the task then waits
    // out SETTLE_CYCLES before the block is taken to be idle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(data);
        @(posedge aclk);
    endtask

    // Writes all six registers while the block is idle and mirrors them in
    // the predictor.
    task automatic program_detector(input int unsigned thr, input int unsigned wake,
                                    input int unsigned min_run, input int unsigned hold,
                                    input int unsigned idle_win,
                                    input int unsigned max_run);
        wait_drained();
        write_reg(REG_SILENCE_THRESHOLD, thr);
        write_reg(REG_WAKE_ENABLE, wake);
        write_reg(REG_MIN_SPEECH, min_run);
        write_reg(REG_SILENCE_HOLD, hold);
        write_reg(REG_IDLE_WINDOW, idle_win);
        write_reg(REG_MAX_SPEECH, max_run);
        cfg_we <= 1'b0;
        set_thr         = THR_W'(thr);
        set_wake        = wake[0];
        set_min_speech  = RUN_W'(min_run);
        set_hold        = RUN_W'(hold);
        set_idle_window = WIN_W'(idle_win);
        set_max_speech  = WIN_W'(max_run);
    endtask

    // Short run lengths and windows, so that every way of ending a capture
    // is reached within a few frames.
    task automatic program_small_random();
        program_detector(($urandom_range(3) == 0) ? $urandom_range(32767)
                                                  : $urandom_range(2000),
                         $urandom_range(1), $urandom_range(1, 4), $urandom_range(1, 4),
                         $urandom_range(2, 12), $urandom_range(2, 10));
    endtask

    // A quiet sample stays well under the silence level; a loud one is any
    // value, with the two extremes and zero favoured.
    function automatic logic signed [15:0] pick_sample(input bit quiet_frame);
        int v;
        if (quiet_frame) begin
            v = $urandom_range(int'(set_thr) / 2);
            if ($urandom_range(1) != 0)
                v = -v;
            return 16'(v);
        end
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed captures: a start, frames of a few samples whose
    // speech flag runs in stretches, idle ticks, and now and then a finalize,
    // an abort, a restart or a stray item. Items that the block just drops
    // are not counted towards n_items.
    task automatic random_traffic(input int n_items, input int tick_pct);
        in_item_t    it;
        int          sent;
        int unsigned r;
        bit          cur_flag;
        bit          quiet_frame;
        bit          counted;
        sent = 0;
        cur_flag = 1'($urandom_range(1));
        quiet_frame = !cur_flag;
        while (sent < n_items) begin
            r = $urandom_range(99);
            it.command     = CMD_SAMPLE;
            it.sample      = 16'($urandom);
            it.frame_last  = 1'($urandom_range(1));
            it.speech_flag = 1'($urandom_range(1));
            if (r < 3) begin
                if ($urandom_range(1) != 0)
                    it.command = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                else
                    it.command = CMD_W'($urandom_range(7));
            end else if (!cap_on) begin
                it.command = (r < 90) ? CMD_START : CMD_FINALIZE;
            end else if (r < 5) begin
                it.command = CMD_ABORT;
            end else if (r < 8) begin
                it.command = CMD_FINALIZE;
            end else if (r < 10) begin
                it.command = CMD_START;
            end else if (r < 10 + tick_pct) begin
                it.command = CMD_TICK;
            end else begin
                it.sample = pick_sample(quiet_frame);
                it.frame_last = ($urandom_range(2) == 0);
                if (it.frame_last) begin
                    it.speech_flag = cur_flag;
                    if ($urandom_range(9) < 3)
                        cur_flag = !cur_flag;
                    quiet_frame = cur_flag ? ($urandom_range(4) == 0)
                                           : ($urandom_range(4) != 0);
                end
            end
            counted = (it.command == CMD_START) || (it.command == CMD_ABORT) ||
                      (it.command == CMD_FINALIZE) ||
                      (cap_on && (it.command == CMD_SAMPLE || it.command == CMD_TICK));
            send_item(it);
            if (counted)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked items: commands while no capture is running, unused
    // command codes, sample extremes, confirmation, and each of the three
    // ways a capture ends, followed by a restart, an abort and a finalize.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        program_detector(1000, 1, 2, 1, 3, 3);
        send_fields(CMD_FINALIZE, 0, 1'b0, 1'b0);
        send_fields(CMD_SAMPLE, 1234, 1'b1, 1'b1);
        send_fields(CMD_TICK, 0, 1'b0, 1'b0);
        send_fields(CMD_UNUSED_LO, -1, 1'b1, 1'b1);
        send_fields(CMD_UNUSED_HI, 0, 1'b1, 1'b0);
        // Confirmed speech, then one quiet silent frame ends the capture.
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        send_fields(CMD_SAMPLE, -32768, 1'b0, 1'b0);
        send_fields(CMD_SAMPLE, 32767, 1'b1, 1'b1);
        send_fields(CMD_SAMPLE, 0, 1'b1, 1'b1);
        send_fields(CMD_SAMPLE, 5, 1'b1, 1'b0);
        // Idle ticks alone run out the window of an empty capture.
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        send_fields(CMD_TICK, 0, 1'b0, 1'b0);
        send_fields(CMD_TICK, 0, 1'b0, 1'b0);
        send_fields(CMD_TICK, 0, 1'b0, 1'b0);
        // Ticks age confirmed speech; the next frame hits the speech limit.
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        send_fields(CMD_SAMPLE, 100, 1'b1, 1'b1);
        send_fields(CMD_SAMPLE, -100, 1'b1, 1'b1);
        send_fields(CMD_TICK, 0, 1'b0, 1'b0);
        send_fields(CMD_TICK, 0, 1'b0, 1'b0);
        send_fields(CMD_SAMPLE, 20000, 1'b1, 1'b1);
        // A start during a capture, an abort, then a finalize with none running.
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        send_fields(CMD_SAMPLE, -7, 1'b1, 1'b0);
        send_fields(CMD_ABORT, 0, 1'b0, 1'b0);
        send_fields(CMD_FINALIZE, 0, 1'b1, 1'b1);
    endtask

    // The reset values written back explicitly, with plenty of ticks so that
    // the long default windows are approached.
    task automatic test_default_settings();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        program_detector(RST_SILENCE_THRESHOLD, RST_WAKE_ENABLE, RST_MIN_SPEECH,
                         RST_SILENCE_HOLD, RST_IDLE_WINDOW, RST_MAX_SPEECH);
        random_traffic(100, 40);
    endtask

    // One frame with no end mark, so that it closes on its sample count,
    // with the sender idling. Loud samples push the energy sum high.
    task automatic test_frame_length_limit();
        send_idle_pct = 63;
        rx_stall_pct  = 0;
        program_detector(655, 1, 1, 1023, 65535, 65535);
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        for (int i = 0; i < FRAME_LEN + 5; i++)
            send_fields(CMD_SAMPLE, (i % 2 == 0) ? -32768 : int'($urandom_range(32767)),
                        1'b0, (i == FRAME_LEN - 1));
        send_fields(CMD_FINALIZE, 0, 1'b0, 1'b0);
    endtask

    // Random captures under one idling pattern, with fresh short settings
    // every few dozen items.
    task automatic test_random_phase(input int sender_pct, input int rx_pct);
        send_idle_pct = sender_pct;
        rx_stall_pct  = rx_pct;
        for (int k = 0; k < 3; k++) begin
            program_small_random();
            random_traffic(25, 15);
        end
    endtask

    // Both ends of the threshold and wake ranges; the other registers at their top and at one.
    task automatic test_register_extremes();
        send_idle_pct = 33;
        rx_stall_pct  = 33;
        program_detector(0, 0, 1023, 1023, 65535, 65535);
        random_traffic(30, 20);
        program_detector(32767, 1, 1, 1, 1, 1);
        random_traffic(30, 20);
    endtask

    // The receiver holds off for a long stretch while one-sample frames keep
    // coming, so the internal queue fills and s_ready drops. The sender then
    // waits for every outstanding result before it goes on.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        program_detector(655, 1, 1023, 1023, 65535, 65535);
        send_fields(CMD_START, 0, 1'b0, 1'b0);
        rx_hold_left = 250;
        for (int i = 0; i < 40; i++)
            send_fields(CMD_SAMPLE, int'($urandom_range(65535)) - 32768, 1'b1,
                        1'($urandom_range(1)));
        wait_drained();
        for (int i = 0; i < 10; i++)
            send_fields(CMD_SAMPLE, int'($urandom_range(65535)) - 32768, 1'b1,
                        1'($urandom_range(1)));
        send_fields(CMD_FINALIZE, 0, 1'b0, 1'b0);
    endtask

    initial begin
        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_default_settings();
        test_frame_length_limit();
        test_random_phase(0, 0);
        test_random_phase(63, 0);
        test_random_phase(0, 63);
        test_random_phase(33, 33);
        test_register_extremes();
        test_output_backpressure();

        // Everything has been sent; let the last results and any stray
        // extra item come out before the verdict.
        wait_drained();
        if (fail_count == 0) begin
            $display("speech_endpoint_detector_unit: match");
        end else begin
            $display("speech_endpoint_detector_unit: mismatch");
        end
        $finish;
    end

endmodule
